### hdl/udpcs_pkg.sv
// Package: shared types, operation codes and ones' complement helpers for the UDP checksum engine.
`timescale 1ns / 1ps
`default_nettype none

package udpcs_pkg;

    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_DATA   = 1'b1;

    localparam int unsigned FIELD_HI_OFFSET = 6;
    localparam int unsigned FIELD_LO_OFFSET = 7;
    localparam int unsigned OFFSET_LIMIT    = 8;

    localparam logic [15:0] ALL_ONES = 16'hFFFF;

    typedef struct packed {
        logic        operation;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [7:0]  protocol_number;
        logic [15:0] segment_length;
        logic [7:0]  data_byte;
        logic        last_byte;
    } item_t;

    // Two-operand ones' complement add with end-around carry.
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] f;
        begin
            s = {1'b0, a} + {1'b0, b};
            f = {1'b0, s[15:0]} + {16'd0, s[16]};
            ones_add = f[15:0];
        end
    endfunction

    // Pseudo-header sum: one wide add of six words, then two carry folds.
    function automatic logic [15:0] pseudo_sum(input item_t it);
        logic [18:0] t;
        logic [16:0] a;
        logic [16:0] b;
        begin
            t = 19'(it.source_address[31:16]) + 19'(it.source_address[15:0])
              + 19'(it.destination_address[31:16]) + 19'(it.destination_address[15:0])
              + 19'(it.protocol_number) + 19'(it.segment_length);
            a = {1'b0, t[15:0]} + {14'd0, t[18:16]};
            b = {1'b0, a[15:0]} + {16'd0, a[16]};
            pseudo_sum = b[15:0];
        end
    endfunction

endpackage

`default_nettype wire

### hdl/udpcs_in_stage.sv
// Input register stage: captures one item per cycle while item_stall is low and holds it until the core takes it.
`timescale 1ns / 1ps
`default_nettype none

module udpcs_in_stage (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  item_valid,
    output logic                 item_stall,
    input  udpcs_pkg::item_t     item_in,
    input  wire                  take,
    output logic                 held_valid,
    output udpcs_pkg::item_t     held_item
);

    logic             valid_reg;
    logic             valid_next;
    udpcs_pkg::item_t item_reg;
    logic             load;

    // Free when empty or when the core consumes the held item this cycle.
    assign item_stall = valid_reg && !take;
    assign load       = item_valid && !item_stall;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

`default_nettype wire

### hdl/udpcs_core.sv
// Checksum core: segment state, at most one ones' complement add per data item, result register.
`timescale 1ns / 1ps
`default_nettype none

module udpcs_core (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  transmit_mode,
    input  wire                  held_valid,
    input  udpcs_pkg::item_t     held_item,
    output logic                 take,
    output logic                 result_valid,
    input  wire                  result_stall,
    output logic [15:0]          checksum_value,
    output logic [15:0]          received_field
);

    logic [15:0] sum_reg, sum_next;
    logic [3:0]  offset_reg, offset_next;
    logic        odd_reg, odd_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic [15:0] captured_reg, captured_next;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_sum_reg, out_field_reg;

    logic        is_data;
    logic        is_last;
    logic        out_free;
    logic [7:0]  byte_eff;
    logic [15:0] cap_upd;
    logic [15:0] add_word;
    logic        do_add;
    logic [15:0] sum_upd;
    logic [15:0] csum;

    assign is_data  = (held_item.operation == udpcs_pkg::OP_DATA);
    assign is_last  = is_data && held_item.last_byte;
    assign out_free = !out_valid_reg || !result_stall;
    // Items without a result never wait on the output side.
    assign take     = held_valid && (!is_last || out_free);

    always_comb
    begin
        byte_eff = held_item.data_byte;
        cap_upd  = captured_reg;
        if (offset_reg == 4'(udpcs_pkg::FIELD_HI_OFFSET))
        begin
            cap_upd  = {held_item.data_byte, captured_reg[7:0]};
            byte_eff = 8'd0;
        end
        else if (offset_reg == 4'(udpcs_pkg::FIELD_LO_OFFSET))
        begin
            cap_upd  = {captured_reg[15:8], held_item.data_byte};
            byte_eff = 8'd0;
        end

        // Complete word, or a lone high byte padded with zero on the last item.
        if (odd_reg)
        begin
            add_word = {held_byte_reg, byte_eff};
            do_add   = 1'b1;
        end
        else
        begin
            add_word = {byte_eff, 8'd0};
            do_add   = held_item.last_byte;
        end
        sum_upd = do_add ? udpcs_pkg::ones_add(sum_reg, add_word) : sum_reg;

        csum = ~sum_upd;
        if (transmit_mode && (csum == 16'd0))
        begin
            csum = udpcs_pkg::ALL_ONES;
        end
    end

    always_comb
    begin
        sum_next       = sum_reg;
        offset_next    = offset_reg;
        odd_next       = odd_reg;
        held_byte_next = held_byte_reg;
        captured_next  = captured_reg;
        if (take)
        begin
            if (!is_data)
            begin
                sum_next       = udpcs_pkg::pseudo_sum(held_item);
                offset_next    = 4'd0;
                odd_next       = 1'b0;
                held_byte_next = 8'd0;
                captured_next  = 16'd0;
            end
            else if (is_last)
            begin
                sum_next       = 16'd0;
                offset_next    = 4'd0;
                odd_next       = 1'b0;
                held_byte_next = 8'd0;
                captured_next  = 16'd0;
            end
            else
            begin
                sum_next       = sum_upd;
                offset_next    = (offset_reg < 4'(udpcs_pkg::OFFSET_LIMIT)) ?
                                 offset_reg + 4'd1 : offset_reg;
                odd_next       = !odd_reg;
                held_byte_next = odd_reg ? 8'd0 : byte_eff;
                captured_next  = cap_upd;
            end
        end
    end

    assign out_valid_next = (take && is_last) ? 1'b1 :
                            (result_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= 16'd0;
            offset_reg    <= 4'd0;
            odd_reg       <= 1'b0;
            held_byte_reg <= 8'd0;
            captured_reg  <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            offset_reg    <= offset_next;
            odd_reg       <= odd_next;
            held_byte_reg <= held_byte_next;
            captured_reg  <= captured_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && is_last)
        begin
            out_sum_reg   <= csum;
            out_field_reg <= cap_upd;
        end
    end

    assign result_valid   = out_valid_reg;
    assign checksum_value = out_sum_reg;
    assign received_field = out_field_reg;

endmodule

`default_nettype wire

### hdl/udp_checksum_engine_top.sv
// Top level of the UDP checksum engine: ports, mode register, input stage and core.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                  Payload
// ------    ------------------------   ------------------------------------------------
// item      item_valid / item_stall    operation, addresses, protocol, length, byte, last
// result    result_valid / result_stall checksum_value, received_field
// config    cfg_write_enable           cfg_write_data (transmit_mode)
//
// One item per cycle sustained while no last-byte item waits on a held result; each item
// takes one pass through a single 16-bit end-around-carry add (header items: one six-word
// add and two carry folds). A result is registered in the input stage and then in the
// result register after its last byte is accepted at the item port.
// Reset clears the segment state, the mode register and both valid flags.
// A held result stalls only the last-byte item behind it; header and other
// data items keep flowing into the core meanwhile, until that item waits in the input stage.

module udp_checksum_engine_top (
    input  wire         clk,
    input  wire         rst_n,

    input  wire         cfg_write_enable,
    input  wire         cfg_write_data,

    input  wire         item_valid,
    output logic        item_stall,
    input  wire         operation,
    input  wire  [31:0] source_address,
    input  wire  [31:0] destination_address,
    input  wire  [7:0]  protocol_number,
    input  wire  [15:0] segment_length,
    input  wire  [7:0]  data_byte,
    input  wire         last_byte,

    output logic        result_valid,
    input  wire         result_stall,
    output logic [15:0] checksum_value,
    output logic [15:0] received_field
);

    logic             transmit_mode_reg;
    logic             transmit_mode_next;
    udpcs_pkg::item_t item_in;
    udpcs_pkg::item_t held_item;
    logic             held_valid;
    logic             take;

    // Mode register: the user must write it only while the engine is idle; the block does not enforce this.
    assign transmit_mode_next = cfg_write_enable ? cfg_write_data : transmit_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            transmit_mode_reg <= 1'b0;
        end
        else
        begin
            transmit_mode_reg <= transmit_mode_next;
        end
    end

    assign item_in.operation           = operation;
    assign item_in.source_address      = source_address;
    assign item_in.destination_address = destination_address;
    assign item_in.protocol_number     = protocol_number;
    assign item_in.segment_length      = segment_length;
    assign item_in.data_byte           = data_byte;
    assign item_in.last_byte           = last_byte;

    udpcs_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_in    (item_in),
        .take       (take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    udpcs_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .transmit_mode  (transmit_mode_reg),
        .held_valid     (held_valid),
        .held_item      (held_item),
        .take           (take),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .checksum_value (checksum_value),
        .received_field (received_field)
    );

endmodule

`default_nettype wire

### bench/tb_top.sv
// Testbench for the UDP checksum engine: random item traffic checked against a built-in predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned STALL_PCT   = 25;    // idle/stall chance per cycle, in percent
    localparam int unsigned CALM_PERIOD = 3000;  // cycles per idle pattern period
    localparam int unsigned CALM_SPAN   = 600;   // leading cycles of each period with no idling
    localparam int unsigned SETTLE      = 10;    // margin for the result to pass the input stage and result register
    localparam int unsigned HANG_LIMIT  = 4000;  // busy cycles with no handshake before giving up

    typedef struct packed {
        logic [15:0] checksum;
        logic [15:0] field;
    } udp_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic cfg_write_enable = 1'b0;
    logic cfg_write_data = 1'b0;

    logic             item_valid = 1'b0;
    logic             item_stall;
    udpcs_pkg::item_t drv_item = '0;

    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [15:0] checksum_value;
    logic [15:0] received_field;

    udpcs_pkg::item_t pending_items[$];
    udp_result_t      expected_results[$];

    // Predictor state, mirrors the engine's segment state.
    logic [15:0] udp_sum = '0;
    int unsigned seg_offset = 0;
    logic        high_held = 1'b0;
    logic [7:0]  held_byte = '0;
    logic [15:0] field_capture = '0;
    logic        tx_mode = 1'b0;

    int unsigned cycle_count = 0;
    int unsigned idle_run = 0;
    int unsigned error_count = 0;
    logic        calm;

    udp_checksum_engine_top uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write_enable    (cfg_write_enable),
        .cfg_write_data      (cfg_write_data),
        .item_valid          (item_valid),
        .item_stall          (item_stall),
        .operation           (drv_item.operation),
        .source_address      (drv_item.source_address),
        .destination_address (drv_item.destination_address),
        .protocol_number     (drv_item.protocol_number),
        .segment_length      (drv_item.segment_length),
        .data_byte           (drv_item.data_byte),
        .last_byte           (drv_item.last_byte),
        .result_valid        (result_valid),
        .result_stall        (result_stall),
        .checksum_value      (checksum_value),
        .received_field      (received_field)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // No idling at all during the first part of each period.
    assign calm = (cycle_count % CALM_PERIOD) < CALM_SPAN;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // 16-bit add with end-around carry.
    function automatic logic [15:0] ones_fold(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[15:0] + {15'd0, s[16]};
        end
    endfunction

    // Advance the predictor by one accepted item; queue the result on a last byte.
    task automatic predict_checksum(input udpcs_pkg::item_t it);
        logic [7:0]  data_val;
        logic [15:0] chk;
        udp_result_t res;
        begin
            if (it.operation == udpcs_pkg::OP_HEADER)
            begin
                udp_sum = ones_fold(16'd0, it.source_address[31:16]);
                udp_sum = ones_fold(udp_sum, it.source_address[15:0]);
                udp_sum = ones_fold(udp_sum, it.destination_address[31:16]);
                udp_sum = ones_fold(udp_sum, it.destination_address[15:0]);
                udp_sum = ones_fold(udp_sum, {8'd0, it.protocol_number});
                udp_sum = ones_fold(udp_sum, it.segment_length);
                seg_offset = 0;
                high_held = 1'b0;
                held_byte = '0;
                field_capture = '0;
            end
            else
            begin
                data_val = it.data_byte;
                // checksum field bytes are captured and summed as zero
                if (seg_offset == udpcs_pkg::FIELD_HI_OFFSET)
                begin
                    field_capture[15:8] = data_val;
                    data_val = '0;
                end
                else if (seg_offset == udpcs_pkg::FIELD_LO_OFFSET)
                begin
                    field_capture[7:0] = data_val;
                    data_val = '0;
                end
                if (seg_offset < udpcs_pkg::OFFSET_LIMIT)
                    seg_offset++;

                if (!high_held)
                begin
                    held_byte = data_val;
                    high_held = 1'b1;
                end
                else
                begin
                    udp_sum = ones_fold(udp_sum, {held_byte, data_val});
                    held_byte = '0;
                    high_held = 1'b0;
                end

                if (it.last_byte)
                begin
                    // odd length: pad the held high byte with a zero low byte
                    if (high_held)
                        udp_sum = ones_fold(udp_sum, {held_byte, 8'h00});
                    chk = ~udp_sum;
                    if (tx_mode && chk == 16'd0)
                        chk = udpcs_pkg::ALL_ONES;
                    res.checksum = chk;
                    res.field = field_capture;
                    expected_results.push_back(res);
                    udp_sum = '0;
                    seg_offset = 0;
                    high_held = 1'b0;
                    held_byte = '0;
                    field_capture = '0;
                end
            end
        end
    endtask

    // Item driver: holds a stalled item, otherwise launches the next one or idles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
                predict_checksum(drv_item);
            if (!item_valid || !item_stall)
            begin
                if (pending_items.size() != 0 && (calm || $urandom_range(99) >= STALL_PCT))
                begin
                    drv_item <= pending_items.pop_front();
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random back-pressure, compares against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        udp_result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: checksum_value %h, received_field %h",
                           checksum_value, received_field);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (checksum_value !== want.checksum)
                    begin
                        $error("checksum_value: expected %h, got %h", want.checksum,
                               checksum_value);
                        error_count++;
                    end
                    if (received_field !== want.field)
                    begin
                        $error("received_field: expected %h, got %h", want.field,
                               received_field);
                        error_count++;
                    end
                end
            end
            result_stall <= !calm && ($urandom_range(99) < STALL_PCT);
        end
    end

    // Hang detection: count busy cycles in which no handshake completes.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_run <= 0;
        else if (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
            idle_run <= idle_run + 1;
        else
            idle_run <= 0;
    end

    initial
    begin
        while (idle_run < HANG_LIMIT)
            @(negedge clk);
        $display("tb_top: FAIL");
        $finish;
    end

    // Unused fields of each item get random values so every input bit toggles.
    task automatic add_header(input logic [31:0] src, input logic [31:0] dst,
                              input logic [7:0] proto, input logic [15:0] len);
        udpcs_pkg::item_t it;
        begin
            it.operation = udpcs_pkg::OP_HEADER;
            it.source_address = src;
            it.destination_address = dst;
            it.protocol_number = proto;
            it.segment_length = len;
            it.data_byte = 8'($urandom);
            it.last_byte = 1'($urandom);
            pending_items.push_back(it);
        end
    endtask

    task automatic add_data(input logic [7:0] val, input logic last);
        udpcs_pkg::item_t it;
        begin
            it.operation = udpcs_pkg::OP_DATA;
            it.source_address = $urandom;
            it.destination_address = $urandom;
            it.protocol_number = 8'($urandom);
            it.segment_length = 16'($urandom);
            it.data_byte = val;
            it.last_byte = last;
            pending_items.push_back(it);
        end
    endtask

    // Pseudo-header sum of 0xFFFF plus a zero word: checksum is zero before the send mapping.
    task automatic queue_zero_sum_case();
        begin
            add_header(32'hFFFF_0000, 32'h0, 8'h00, 16'h0000);
            add_data(8'h00, 1'b0);
            add_data(8'h00, 1'b1);
        end
    endtask

    task automatic queue_directed_items();
        begin
            // no header since reset, odd length, high bit set in the padded byte
            add_data(8'hC3, 1'b0);
            add_data(8'h5A, 1'b0);
            add_data(8'h80, 1'b1);
            // all-ones pseudo header and a full 8-byte header with the field captured
            add_header(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
            for (int i = 0; i < 8; i++)
                add_data(8'hFF, i == 7);
            queue_zero_sum_case();
            // short segment: only the high byte of the checksum field arrives
            add_header(32'hC0A8_0001, 32'h0A00_0002, 8'd17, 16'd7);
            for (int i = 0; i < 7; i++)
                add_data(8'(8'h11 * (i + 1)), i == 6);
        end
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random_traffic(input int unsigned count);
        int unsigned start;
        int unsigned roll;
        int unsigned seg_len;
        logic [31:0] len_word;
        logic [7:0]  proto;
        begin
            start = pending_items.size();
            while (pending_items.size() - start < count)
            begin
                roll = $urandom_range(99);
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5, 6: seg_len = $urandom_range(12, 1);
                    7, 8:                seg_len = $urandom_range(40, 13);
                    default:             seg_len = $urandom_range(200, 41);
                endcase
                if (roll < 85)
                begin
                    // well-formed segment behind a pseudo header
                    proto = ($urandom_range(3) == 0) ? 8'(pick_word()) : 8'd17;
                    len_word = ($urandom_range(3) == 0) ? pick_word() : 32'(seg_len);
                    add_header(pick_word(), pick_word(), proto, len_word[15:0]);
                    for (int unsigned i = 0; i < seg_len; i++)
                        add_data(8'(pick_word()), i == seg_len - 1);
                end
                else if (roll < 92)
                begin
                    // data with no pseudo header in front
                    for (int unsigned i = 0; i < seg_len; i++)
                        add_data(8'(pick_word()), i == seg_len - 1);
                end
                else if (roll < 96)
                begin
                    // lone header, restarted by whatever follows
                    add_header(pick_word(), pick_word(), 8'(pick_word()), 16'(pick_word()));
                end
                else
                begin
                    // broken segment: no last byte, next header restarts the sum
                    add_header(pick_word(), pick_word(), 8'd17, 16'(seg_len));
                    for (int unsigned i = 0; i < seg_len; i++)
                        add_data(8'(pick_word()), 1'b0);
                end
            end
        end
    endtask

    task automatic wait_drained();
        begin
            while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
                @(negedge clk);
        end
    endtask

    // Mode writes only with the engine idle; allow trailing items to clear the core.
    task automatic set_tx_mode(input logic mode);
        begin
            wait_drained();
            repeat (SETTLE) @(posedge clk);
            cfg_write_enable <= 1'b1;
            cfg_write_data <= mode;
            @(posedge clk);
            cfg_write_enable <= 1'b0;
            tx_mode = mode;
            @(negedge clk);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_directed_items();
        set_tx_mode(1'b1);
        queue_zero_sum_case();
        queue_random_traffic(450);
        set_tx_mode(1'b0);
        queue_random_traffic(450);
        set_tx_mode(1'b1);
        queue_random_traffic(400);
        set_tx_mode(1'b0);
        queue_random_traffic(400);

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

### filelist.f
hdl/udpcs_pkg.sv
hdl/udpcs_in_stage.sv
hdl/udpcs_core.sv
hdl/udp_checksum_engine_top.sv
bench/tb_top.sv
